// ----- sv/brcd_pkg.sv -----
`timescale 1ns / 1ps

package brcd_pkg;

  localparam int unsigned BUTTON_COUNT = 120;

  // fixed field widths
  localparam int unsigned LOW_W   = 64;
  localparam int unsigned HIGH_W  = 56;
  localparam int unsigned ENC_W   = 4;
  localparam int unsigned INDEX_W = 7;

  localparam int unsigned CNT_W = $clog2(BUTTON_COUNT);

  localparam int unsigned SHIFT_BUTTON = 105;
  localparam int unsigned LAST_SCANNED = 116;
  localparam int unsigned PAD_FIRST    = 18;
  localparam int unsigned PAD_LAST     = 81;

  localparam bit SHIFT_STORED = (SHIFT_BUTTON < BUTTON_COUNT);
  localparam int unsigned SCAN_LAST =
    ((BUTTON_COUNT - 1) > LAST_SCANNED) ? LAST_SCANNED : (BUTTON_COUNT - 1);

  localparam logic [ENC_W-1:0] ENC_TOP    = 4'h0f;
  localparam logic [ENC_W-1:0] ENC_BOTTOM = 4'h00;

  typedef enum logic [1:0] {
    KIND_NONE    = 2'd0,
    KIND_PAD     = 2'd1,
    KIND_BUTTON  = 2'd2,
    KIND_ENCODER = 2'd3
  } event_kind_t;

  typedef struct packed {
    logic load;
    logic shift;
  } cell_ctl_t;

endpackage

// ----- sv/brcd_report_if.sv -----
`timescale 1ns / 1ps

interface brcd_report_if;
  logic                              valid;
  logic                              ready;
  logic [brcd_pkg::LOW_W-1:0]        buttons_low;
  logic [brcd_pkg::HIGH_W-1:0]       buttons_high;
  logic [brcd_pkg::ENC_W-1:0]        encoder_position;

  modport source (output valid, buttons_low, buttons_high, encoder_position, input ready);
  modport sink   (input valid, buttons_low, buttons_high, encoder_position, output ready);
endinterface

// ----- sv/brcd_result_if.sv -----
`timescale 1ns / 1ps

interface brcd_result_if;
  logic                          valid;
  logic                          ready;
  logic [1:0]                    event_kind;
  logic [brcd_pkg::INDEX_W-1:0]  event_index;
  logic                          is_pressed;
  logic                          turned_up;
  logic                          shift_held;

  modport source (output valid, event_kind, event_index, is_pressed, turned_up, shift_held,
                  input ready);
  modport sink   (input valid, event_kind, event_index, is_pressed, turned_up, shift_held,
                  output ready);
endinterface

// ----- sv/button_report_change_detector.sv -----
`timescale 1ns / 1ps

// Channel  Dir  Payload                                              Handshake
// report   in   buttons_low, buttons_high, encoder_position           valid/ready
// result   out  event_kind, event_index, is_pressed, turned_up,        valid/ready
//               shift_held
//
// Each item is accepted, then the button cell ring rotates one step per cycle
// through every cell, then the result is formed.
// The ring rotation, one button bit through the head per cycle, sets the rate.
// Synchronous reset clears all button memories and the encoder position.
// A new item is taken while the last result waits; the scan stalls at its end
// only while that result is still unread.
module button_report_change_detector (
  input  logic          clk,
  input  logic          rst,
  brcd_report_if.sink   report,
  brcd_result_if.source result
);

  localparam int unsigned N = brcd_pkg::BUTTON_COUNT;

  brcd_pkg::cell_ctl_t                        ctl;
  logic [brcd_pkg::LOW_W+brcd_pkg::HIGH_W-1:0] bits;
  logic [N-1:0]                               mem;
  logic [N-1:0]                               key;
  logic                                       fb_mem;

  assign bits = {report.buttons_high, report.buttons_low};

  for (genvar i = 0; i < N; i++) begin : g_cell
    logic nm;
    logic nk;
    if (i == N - 1) begin : g_tail
      assign nm = fb_mem;
      assign nk = 1'b0;
    end else begin : g_body
      assign nm = mem[i+1];
      assign nk = key[i+1];
    end
    brcd_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .ctl      (ctl),
      .load_bit (bits[i]),
      .next_mem (nm),
      .next_key (nk),
      .mem      (mem[i]),
      .key      (key[i])
    );
  end

  brcd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .report   (report),
    .result   (result),
    .head_mem (mem[0]),
    .head_key (key[0]),
    .fb_mem   (fb_mem),
    .ctl      (ctl)
  );

`ifndef SYNTH
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    report.valid && report.ready |=> !report.ready)
    else $error("report taken while a scan is under way");

  a_none_is_clean: assert property (@(posedge clk) disable iff (rst)
    result.valid && result.event_kind == brcd_pkg::KIND_NONE |->
      result.event_index == '0 && !result.is_pressed && !result.turned_up)
    else $error("empty result carries event data");

  a_encoder_no_index: assert property (@(posedge clk) disable iff (rst)
    result.valid && result.event_kind == brcd_pkg::KIND_ENCODER |->
      result.event_index == '0 && !result.is_pressed)
    else $error("encoder result carries button data");

  a_pad_range: assert property (@(posedge clk) disable iff (rst)
    result.valid && result.event_kind == brcd_pkg::KIND_PAD |->
      result.event_index <= brcd_pkg::INDEX_W'(brcd_pkg::PAD_LAST - brcd_pkg::PAD_FIRST)
      && !result.turned_up)
    else $error("pad result out of range");
`endif

endmodule

// ----- sv/brcd_cell.sv -----
`timescale 1ns / 1ps

// One button: remembered state plus the bit of the current report.
module brcd_cell (
  input  logic                clk,
  input  logic                rst,
  input  brcd_pkg::cell_ctl_t ctl,
  input  logic                load_bit,
  input  logic                next_mem,
  input  logic                next_key,
  output logic                mem,
  output logic                key
);

  always_ff @(posedge clk) begin
    if (rst) begin
      mem <= 1'b0;
    end else if (ctl.shift) begin
      mem <= next_mem;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      key <= load_bit;
    end else if (ctl.shift) begin
      key <= next_key;
    end
  end

endmodule

// ----- sv/brcd_ctrl.sv -----
`timescale 1ns / 1ps

// Watches the head of the cell ring, picks the first change, builds the result.
module brcd_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  brcd_report_if.sink          report,
  brcd_result_if.source        result,
  input  logic                 head_mem,
  input  logic                 head_key,
  output logic                 fb_mem,
  output brcd_pkg::cell_ctl_t  ctl
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_FINISH
  } state_t;

  state_t                          state;
  logic [brcd_pkg::CNT_W-1:0]      cnt;
  logic                            found;
  logic [brcd_pkg::ENC_W-1:0]      enc_new;
  logic [brcd_pkg::ENC_W-1:0]      last_enc;
  logic                            shift_now;
  brcd_pkg::event_kind_t           hit_kind;
  logic [brcd_pkg::INDEX_W-1:0]    hit_index;
  logic                            hit_pressed;

  logic [brcd_pkg::INDEX_W-1:0]    pos;
  logic                            at_shift;
  logic                            scanned;
  logic                            take;
  logic                            is_pad;
  logic                            enc_up;

  assign pos      = brcd_pkg::INDEX_W'(cnt);
  assign at_shift = (pos == brcd_pkg::INDEX_W'(brcd_pkg::SHIFT_BUTTON));
  assign scanned  = (pos <= brcd_pkg::INDEX_W'(brcd_pkg::SCAN_LAST)) && !at_shift;
  assign take     = (state == S_SCAN) && scanned && !found && (head_mem != head_key);
  assign is_pad   = (pos >= brcd_pkg::INDEX_W'(brcd_pkg::PAD_FIRST)) &&
                    (pos <= brcd_pkg::INDEX_W'(brcd_pkg::PAD_LAST));

  // shift is always stored; otherwise only the reported change is
  assign fb_mem = (take || at_shift) ? head_key : head_mem;

  assign enc_up = ((last_enc < enc_new) ||
                   (last_enc == brcd_pkg::ENC_TOP && enc_new == brcd_pkg::ENC_BOTTOM)) &&
                  !(last_enc == brcd_pkg::ENC_BOTTOM && enc_new == brcd_pkg::ENC_TOP);

  assign report.ready = (state == S_IDLE);
  assign ctl.load     = (state == S_IDLE) && report.valid;
  assign ctl.shift    = (state == S_SCAN);

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      cnt          <= '0;
      found        <= 1'b0;
      last_enc     <= '0;
      result.valid <= 1'b0;
    end else begin
      // in S_FINISH the result register is reloaded below instead
      if (result.valid && result.ready && state != S_FINISH) begin
        result.valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (report.valid) begin
            state       <= S_SCAN;
            cnt         <= '0;
            found       <= 1'b0;
            enc_new     <= report.encoder_position;
            shift_now   <= brcd_pkg::SHIFT_STORED ?
                           report.buttons_high[brcd_pkg::SHIFT_BUTTON - brcd_pkg::LOW_W] :
                           1'b0;
            hit_kind    <= brcd_pkg::KIND_NONE;
            hit_index   <= '0;
            hit_pressed <= 1'b0;
          end
        end
        S_SCAN: begin
          if (take) begin
            found       <= 1'b1;
            hit_pressed <= head_key;
            if (is_pad) begin
              hit_kind  <= brcd_pkg::KIND_PAD;
              hit_index <= pos - brcd_pkg::INDEX_W'(brcd_pkg::PAD_FIRST);
            end else begin
              hit_kind  <= brcd_pkg::KIND_BUTTON;
              hit_index <= pos;
            end
          end
          if (cnt == brcd_pkg::CNT_W'(brcd_pkg::BUTTON_COUNT - 1)) begin
            state <= S_FINISH;
          end else begin
            cnt <= cnt + brcd_pkg::CNT_W'(1);
          end
        end
        S_FINISH: begin
          if (!result.valid || result.ready) begin
            result.valid       <= 1'b1;
            result.shift_held  <= shift_now;
            result.event_index <= hit_index;
            result.is_pressed  <= hit_pressed;
            state              <= S_IDLE;
            if (!found && (enc_new != last_enc)) begin
              result.event_kind <= brcd_pkg::KIND_ENCODER;
              result.turned_up  <= enc_up;
              last_enc          <= enc_new;
            end else begin
              result.event_kind <= hit_kind;
              result.turned_up  <= 1'b0;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ----- dv/tb_button_report_change_detector.sv -----
`timescale 1ns / 1ps

module tb_button_report_change_detector;

  typedef struct packed {
    logic [brcd_pkg::LOW_W-1:0]  lo;
    logic [brcd_pkg::HIGH_W-1:0] hi;
    logic [brcd_pkg::ENC_W-1:0]  pos;
  } report_t;

  typedef struct packed {
    brcd_pkg::event_kind_t        kind;
    logic [brcd_pkg::INDEX_W-1:0] index;
    logic                         pressed;
    logic                         up;
    logic                         shift;
  } key_event_t;

  localparam int unsigned MAP_W     = brcd_pkg::LOW_W + brcd_pkg::HIGH_W;
  localparam logic [MAP_W-1:0] ONE  = MAP_W'(1);
  localparam int RANDOM_REPORTS     = 1330;
  localparam int STALL_AT           = 200;
  localparam int STALL_CYCLES       = 800;
  localparam int DRAIN_AT           = 900;
  localparam int SETTLE_CYCLES      = 150;

  logic clk;
  logic rst;

  brcd_report_if report_ch ();
  brcd_result_if result_ch ();

  button_report_change_detector dut (
    .clk    (clk),
    .rst    (rst),
    .report (report_ch),
    .result (result_ch)
  );

  report_t    report_q[$];
  key_event_t event_q[$];

  // shadow of the block's memories
  bit                         held[brcd_pkg::BUTTON_COUNT];
  logic [brcd_pkg::ENC_W-1:0] enc_seen;

  int sent_n;
  int got_n;
  int err_n;
  int third;
  bit drained;
  bit stall_done;
  int stall_left;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("== FAIL ==");
    $finish;
  end

  function automatic key_event_t predict_event(input logic [MAP_W-1:0] map,
                                               input logic [brcd_pkg::ENC_W-1:0] pos);
    key_event_t ev;
    bit         hit;
    ev  = '{brcd_pkg::KIND_NONE, '0, 1'b0, 1'b0, 1'b0};
    hit = 1'b0;
    if (brcd_pkg::SHIFT_STORED) begin
      ev.shift = map[brcd_pkg::SHIFT_BUTTON];
      held[brcd_pkg::SHIFT_BUTTON] = map[brcd_pkg::SHIFT_BUTTON];
    end
    for (int n = 0; n <= int'(brcd_pkg::SCAN_LAST); n++) begin
      if (!hit && n != int'(brcd_pkg::SHIFT_BUTTON) && map[n] != held[n]) begin
        hit = 1'b1;
        held[n] = map[n];
        if (n >= int'(brcd_pkg::PAD_FIRST) && n <= int'(brcd_pkg::PAD_LAST)) begin
          ev.kind  = brcd_pkg::KIND_PAD;
          ev.index = brcd_pkg::INDEX_W'(n - int'(brcd_pkg::PAD_FIRST));
        end else begin
          ev.kind  = brcd_pkg::KIND_BUTTON;
          ev.index = brcd_pkg::INDEX_W'(n);
        end
        ev.pressed = map[n];
      end
    end
    if (!hit && pos != enc_seen) begin
      ev.kind = brcd_pkg::KIND_ENCODER;
      ev.up   = ((enc_seen < pos) ||
                 (enc_seen == brcd_pkg::ENC_TOP && pos == brcd_pkg::ENC_BOTTOM)) &&
                !(enc_seen == brcd_pkg::ENC_BOTTOM && pos == brcd_pkg::ENC_TOP);
      enc_seen = pos;
    end
    return ev;
  endfunction

  function automatic void add_report(input logic [MAP_W-1:0] map,
                                     input logic [brcd_pkg::ENC_W-1:0] pos);
    report_q.push_back('{map[brcd_pkg::LOW_W-1:0], map[MAP_W-1:brcd_pkg::LOW_W], pos});
  endfunction

  // 0: sender light / receiver heavy, 1: the reverse, 2: no idling
  function automatic int stage();
    if (sent_n < third) return 0;
    if (sent_n < 2 * third) return 1;
    return 2;
  endfunction

  // sender
  always @(posedge clk) begin
    report_t nxt;
    int      gap;
    if (rst) begin
      report_ch.valid <= 1'b0;
    end else begin
      if (report_ch.valid && report_ch.ready) begin
        event_q.push_back(predict_event({report_ch.buttons_high, report_ch.buttons_low},
                                        report_ch.encoder_position));
        sent_n++;
      end
      if (sent_n == DRAIN_AT && !drained && event_q.size() == 0)
        drained = 1'b1;
      if (!report_ch.valid || report_ch.ready) begin
        gap = (stage() == 0) ? 9 : (stage() == 1) ? 66 : 0;
        if (report_q.size() != 0 && (sent_n != DRAIN_AT || drained) &&
            $urandom_range(99) >= gap) begin
          nxt = report_q.pop_front();
          report_ch.buttons_low      <= nxt.lo;
          report_ch.buttons_high     <= nxt.hi;
          report_ch.encoder_position <= nxt.pos;
          report_ch.valid            <= 1'b1;
        end else begin
          report_ch.valid <= 1'b0;
        end
      end
    end
  end

  // receiver, with one long hold-off to back the block up
  always @(posedge clk) begin
    int gap;
    if (rst) begin
      result_ch.ready <= 1'b0;
    end else if (stall_left != 0) begin
      stall_left      <= stall_left - 1;
      result_ch.ready <= 1'b0;
    end else if (!stall_done && got_n >= STALL_AT) begin
      stall_done      <= 1'b1;
      stall_left      <= STALL_CYCLES;
      result_ch.ready <= 1'b0;
    end else begin
      gap = (stage() == 0) ? 66 : (stage() == 1) ? 9 : 0;
      result_ch.ready <= ($urandom_range(99) >= gap);
    end
  end

  // checker
  always @(posedge clk) begin
    key_event_t want;
    if (!rst && result_ch.valid && result_ch.ready) begin
      got_n++;
      if (event_q.size() == 0) begin
        if (err_n < 10)
          $display("%0t: unexpected event kind=%0d index=%0d", $realtime,
                   result_ch.event_kind, result_ch.event_index);
        err_n++;
      end else begin
        want = event_q.pop_front();
        if (result_ch.event_kind !== want.kind || result_ch.event_index !== want.index ||
            result_ch.is_pressed !== want.pressed || result_ch.turned_up !== want.up ||
            result_ch.shift_held !== want.shift) begin
          if (err_n < 10)
            $display({"%0t: event %0d exp kind=%0d idx=%0d prs=%0b up=%0b sh=%0b",
                      " got %0d %0d %0b %0b %0b"},
                     $realtime, got_n, want.kind, want.index, want.pressed, want.up,
                     want.shift, result_ch.event_kind, result_ch.event_index,
                     result_ch.is_pressed, result_ch.turned_up, result_ch.shift_held);
          err_n++;
        end
      end
    end
  end

  initial begin
    logic [MAP_W-1:0]           map;
    logic [brcd_pkg::ENC_W-1:0] pos;
    int                         pick;
    rst                        = 1'b1;
    report_ch.valid            = 1'b0;
    report_ch.buttons_low      = '0;
    report_ch.buttons_high     = '0;
    report_ch.encoder_position = '0;
    result_ch.ready            = 1'b0;
    for (int i = 0; i < int'(brcd_pkg::BUTTON_COUNT); i++) held[i] = 1'b0;
    enc_seen   = '0;
    sent_n     = 0;
    got_n      = 0;
    err_n      = 0;
    drained    = 1'b0;
    stall_done = 1'b0;
    stall_left = 0;

    // encoder moves, wraps both ways
    add_report('0, 4'd0);
    add_report('0, 4'd1);
    add_report('0, 4'd0);
    add_report('0, brcd_pkg::ENC_TOP);
    add_report('0, brcd_pkg::ENC_BOTTOM);
    // shift alone, and the unscanned top buttons
    add_report(ONE << brcd_pkg::SHIFT_BUTTON, 4'd0);
    add_report((ONE << brcd_pkg::SHIFT_BUTTON) | (ONE << 117) | (ONE << 118) | (ONE << 119),
               4'd0);
    // button with encoder move: move waits for the next report
    map = ONE | (ONE << brcd_pkg::SHIFT_BUTTON);
    add_report(map, 4'd3);
    add_report(map, 4'd3);
    // pad range edges and neighbours
    map |= ONE << brcd_pkg::PAD_FIRST;
    add_report(map, 4'd3);
    map |= ONE << brcd_pkg::PAD_LAST;
    add_report(map, 4'd3);
    map |= ONE << (brcd_pkg::PAD_FIRST - 1);
    add_report(map, 4'd3);
    map |= ONE << (brcd_pkg::PAD_LAST + 1);
    add_report(map, 4'd3);
    map |= ONE << brcd_pkg::LAST_SCANNED;
    add_report(map, 4'd3);
    // everything pressed, then released, backlog drains one per report
    add_report('1, brcd_pkg::ENC_TOP);
    add_report('1, brcd_pkg::ENC_TOP);
    add_report('1, brcd_pkg::ENC_TOP);
    add_report('0, brcd_pkg::ENC_BOTTOM);
    add_report('0, brcd_pkg::ENC_BOTTOM);
    add_report('0, brcd_pkg::ENC_BOTTOM);
    add_report({MAP_W{1'b1}}, brcd_pkg::ENC_TOP);
    add_report({MAP_W{1'b1}}, 4'd14);

    // mostly small edits to a held bitmap so deep buttons get reported
    map = '1;
    pos = 4'd14;
    for (int i = 0; i < RANDOM_REPORTS; i++) begin
      pick = $urandom_range(99);
      if (pick < 70) begin
        repeat ($urandom_range(3)) map[$urandom_range(MAP_W - 1)] ^= 1'b1;
      end else if (pick >= 88) begin
        map = MAP_W'({$urandom, $urandom, $urandom, $urandom});
      end
      pick = $urandom_range(99);
      if (pick < 30) pos = pos + 1'b1;
      else if (pick < 55) pos = pos - 1'b1;
      else if (pick < 65) pos = brcd_pkg::ENC_W'($urandom_range(15));
      add_report(map, pos);
    end
    third = report_q.size() / 3;

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    while (report_q.size() != 0 || report_ch.valid) @(posedge clk);
    while (event_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (err_n == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
